/* rtl/prd_pkg.sv */
// Shared types and constants for the packed run-length row decoder.
`default_nettype none
package prd_pkg;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 5;
  localparam int KEY_W    = 3;
  localparam int LEFT_W   = 6;
  localparam int TOTAL_W  = 17;
  localparam int MINLEN_W = 16;

  localparam logic [KEY_W-1:0]    KEY_LITERAL    = 3'd7;
  localparam logic [MINLEN_W-1:0] MIN_LEN_RESET  = 16'd32;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One queued command: emit value (cnt + 1) times.
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [LEN_W-1:0]  cnt;
    logic              seg_last;
  } prd_cmd_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } prd_q_stat_t;

endpackage
`default_nettype wire

/* rtl/prd_front.sv */
// Front part: accepts packed bytes, tracks literal state, issues emit commands.
`default_nettype none
module prd_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [prd_pkg::BYTE_W-1:0]    in_tdata,
  input  wire prd_pkg::prd_q_stat_t          q_stat,
  output logic                               push,
  output prd_pkg::prd_cmd_t                  push_cmd
);
  import prd_pkg::*;

  logic [LEFT_W-1:0] literal_left_r, literal_left_nxt;
  logic              accept;
  logic [KEY_W-1:0]  key;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign key       = in_tdata[BYTE_W-1 -: KEY_W];

  always_comb begin
    literal_left_nxt = literal_left_r;
    push             = 1'b0;
    push_cmd.value   = in_tdata;
    push_cmd.cnt     = '0;
    push_cmd.seg_last = 1'b0;
    if (accept) begin
      if (literal_left_r != '0) begin
        push              = 1'b1;
        push_cmd.seg_last = (literal_left_r == LEFT_W'(1));
        literal_left_nxt  = literal_left_r - LEFT_W'(1);
      end else if (key == KEY_LITERAL) begin
        literal_left_nxt = LEFT_W'(in_tdata[LEN_W-1:0]) + LEFT_W'(1);
      end else begin
        push              = 1'b1;
        push_cmd.value    = BYTE_W'(key);
        push_cmd.cnt      = in_tdata[LEN_W-1:0];
        push_cmd.seg_last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      literal_left_r <= '0;
    end else begin
      literal_left_r <= literal_left_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/prd_fifo.sv */
// Short command queue between the front and back parts.
`default_nettype none
module prd_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire prd_pkg::prd_cmd_t    push_cmd,
  input  wire logic                 pop,
  output prd_pkg::prd_cmd_t         head_cmd,
  output prd_pkg::prd_q_stat_t      q_stat
);
  import prd_pkg::*;

  prd_cmd_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r;
  logic                 do_push, do_pop;

  assign q_stat.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_cmd     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + Q_CNT_W'(1);
        2'b01:   count_r <= count_r - Q_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/prd_back.sv */
// Back part: expands commands into bytes, tracks row total, drives output register.
`default_nettype none
module prd_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [prd_pkg::MINLEN_W-1:0]  cfg_wr_data,
  input  wire prd_pkg::prd_cmd_t             head_cmd,
  input  wire prd_pkg::prd_q_stat_t          q_stat,
  output logic                               pop,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [prd_pkg::BYTE_W-1:0]         out_tdata,
  output logic                               out_tlast,
  output logic                               out_tuser
);
  import prd_pkg::*;

  logic [MINLEN_W-1:0] min_len_r;
  logic [TOTAL_W-1:0]  row_total_r, row_total_nxt, tot_inc;
  prd_cmd_t            cur_r;
  logic [LEN_W-1:0]    left_r;
  logic                active_r;
  logic                out_valid_r;
  logic [BYTE_W-1:0]   out_byte_r;
  logic                out_last_r, out_chunk_r;
  logic                load_ok, emit, done, seg_end, chunk;

  assign load_ok = !out_valid_r || out_tready;
  assign emit    = active_r && load_ok;
  assign done    = emit && (left_r == '0);
  assign pop     = !q_stat.empty && (!active_r || done);
  assign seg_end = (left_r == '0) && cur_r.seg_last;
  assign tot_inc = row_total_r + TOTAL_W'(1);
  assign chunk   = seg_end && (tot_inc >= TOTAL_W'(min_len_r));

  always_comb begin
    row_total_nxt = row_total_r;
    if (emit) row_total_nxt = chunk ? '0 : tot_inc;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_chunk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r   <= MIN_LEN_RESET;
      row_total_r <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) min_len_r <= cfg_wr_data;
      row_total_r <= row_total_nxt;
      if (pop)       active_r <= 1'b1;
      else if (done) active_r <= 1'b0;
      if (emit)           out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r  <= head_cmd;
      left_r <= head_cmd.cnt;
    end else if (emit) begin
      left_r <= left_r - LEN_W'(1);
    end
    if (emit) begin
      out_byte_r  <= cur_r.value;
      out_last_r  <= seg_end;
      out_chunk_r <= chunk;
    end
  end

endmodule
`default_nettype wire

/* rtl/packed_rle_row_decoder_core.sv */
// Top level of the packed run-length row decoder.
//
//  channel | dir | payload                                  | handshake
//  in_     | in  | tdata[7:0] packed_byte                   | tvalid/tready
//  out_    | out | tdata[7:0] out_byte, tlast segment_last, | tvalid/tready
//          |     | tuser chunk_end                          |
//  cfg_    | in  | wr_data[15:0] min_row_length             | wr_en
//
// One output byte per cycle unless stalled or starved; a run code n yields n + 1 bytes.
// A literal header is accepted and yields nothing; each literal byte yields one.
// Input accepts one byte a cycle until the 4-entry command queue fills behind a long run.
// Synchronous reset, no clearing pass; min_row_length resets to 32.
// Output stalls hold the output register and back up through the queue to in_tready.
`default_nettype none
module packed_rle_row_decoder_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,    // [7:0] packed_byte
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [7:0]                         out_tdata,   // [7:0] out_byte
  output logic                               out_tlast,   // segment_last
  output logic                               out_tuser,   // [0] chunk_end
  input  wire logic                          cfg_wr_en,
  input  wire logic [prd_pkg::MINLEN_W-1:0]  cfg_wr_data
);
  import prd_pkg::*;

  prd_cmd_t    push_cmd, head_cmd;
  prd_q_stat_t q_stat;
  logic        push, pop;

  prd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  prd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  prd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head_cmd    (head_cmd),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule
`default_nettype wire

/* rtl/prd_checker.sv */
// Port-level assertions for the packed run-length row decoder, bound to the top level.
`default_nettype none
module prd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tlast,
  input wire logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped during stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("output transaction changed during stall");

  a_chunk_on_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("chunk end without segment end");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind packed_rle_row_decoder_core prd_checker u_prd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire

/* sim/prd_unpack_monitor.sv */
// Channel monitor for the packed run-length row decoder: predicts unpacked bytes and checks them.
module prd_unpack_monitor (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  input  wire logic                         in_tready,
  input  wire logic [7:0]                   in_tdata,
  input  wire logic                         out_tvalid,
  input  wire logic                         out_tready,
  input  wire logic [7:0]                   out_tdata,
  input  wire logic                         out_tlast,
  input  wire logic                         out_tuser,
  input  wire logic                         cfg_wr_en,
  input  wire logic [prd_pkg::MINLEN_W-1:0] cfg_wr_data,
  output int                                fail_count,
  output int                                pending
);
  import prd_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              seg_end;
    logic              chunk_end;
  } unpacked_t;

  unpacked_t             unpacked_q[$];
  logic [MINLEN_W-1:0]   min_len;
  logic [LEFT_W-1:0]     lit_left;
  logic [TOTAL_W-1:0]    row_total;
  int                    errs = 0;

  // Segment done: add its bytes to the chunk and decide the chunk end flag.
  function automatic logic close_chunk_segment(input int unsigned n);
    row_total = row_total + TOTAL_W'(n);
    if (row_total >= {1'b0, min_len}) begin
      row_total = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void unpack_byte(input logic [BYTE_W-1:0] b);
    logic [KEY_W-1:0] key;
    int unsigned      len;
    unpacked_t        u;
    key = b[BYTE_W-1 -: KEY_W];
    len = int'(b[LEN_W-1:0]) + 1;
    if (lit_left != '0) begin
      lit_left    = lit_left - LEFT_W'(1);
      u.value     = b;
      u.seg_end   = (lit_left == '0);
      u.chunk_end = 1'b0;
      if (lit_left == '0) begin
        u.chunk_end = close_chunk_segment(1);
      end else begin
        row_total = row_total + TOTAL_W'(1);
      end
      unpacked_q = {unpacked_q, u};
    end else if (key == KEY_LITERAL) begin
      lit_left = LEFT_W'(len);
    end else begin
      for (int unsigned i = 0; i < len; i++) begin
        u.value     = BYTE_W'(key);
        u.seg_end   = (i == len - 1);
        u.chunk_end = (i == len - 1) ? close_chunk_segment(len) : 1'b0;
        unpacked_q = {unpacked_q, u};
      end
    end
  endfunction

  always @(posedge clk) begin
    unpacked_t got;
    unpacked_t want;
    if (!rst_n) begin
      min_len   = MIN_LEN_RESET;
      lit_left  = '0;
      row_total = '0;
      unpacked_q.delete();
    end else begin
      if (cfg_wr_en) begin
        min_len = cfg_wr_data;
      end
      if (in_tvalid && in_tready) begin
        unpack_byte(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        got.value     = out_tdata;
        got.seg_end   = out_tlast;
        got.chunk_end = out_tuser;
        if (unpacked_q.size() == 0) begin
          if (errs < 10) begin
            $display("%0t: unexpected transaction data %02h last %0b chunk_end %0b",
                     $realtime, got.value, got.seg_end, got.chunk_end);
          end
          errs++;
        end else begin
          want = unpacked_q.pop_front();
          if (got.value != want.value || got.seg_end != want.seg_end ||
              got.chunk_end != want.chunk_end) begin
            if (errs < 10) begin
              $display("%0t: mismatch data %02h/%02h last %0b/%0b chunk_end %0b/%0b (exp/got)",
                       $realtime, want.value, got.value, want.seg_end, got.seg_end,
                       want.chunk_end, got.chunk_end);
            end
            errs++;
          end
        end
      end
    end
    fail_count <= errs;
    pending    <= unpacked_q.size();
  end

endmodule

/* sim/packed_rle_row_decoder_core_tb.sv */
// Testbench top for the packed run-length row decoder: stimulus, flow control and verdict.
module packed_rle_row_decoder_core_tb;
  import prd_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [7:0]          out_tdata;
  logic                out_tlast;
  logic                out_tuser;
  logic                cfg_wr_en;
  logic [MINLEN_W-1:0] cfg_wr_data;
  int                  fail_count;
  int                  pending;
  bit                  steady;
  bit                  hold_req;

  packed_rle_row_decoder_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  prd_unpack_monitor unpack_mon (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // Length code: mostly short runs, sometimes the longest.
  function automatic logic [LEN_W-1:0] pick_len_code();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return LEN_W'($urandom_range(0, 7));
    if (r == 8) return '1;
    return LEN_W'($urandom_range(0, 31));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = steady ? 0 : (($urandom_range(0, 2) == 0) ? pick_gap() : 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain all results, let the block settle, then write the minimum row length.
  task automatic set_min_len(input logic [MINLEN_W-1:0] v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_segments(input int n_items);
    int               sent;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] lc;
    sent = 0;
    while (sent < n_items) begin
      lc = pick_len_code();
      if ($urandom_range(0, 9) < 6) begin
        key = KEY_W'($urandom_range(0, 6));
        send_byte({key, lc});
        sent++;
      end else begin
        send_byte({KEY_LITERAL, lc});
        sent++;
        repeat (int'(lc) + 1) begin
          send_byte(8'($urandom_range(0, 255)));
          sent++;
        end
      end
    end
  endtask

  // Receiver: random back-pressure, one long hold-off on request.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (steady || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
    end
  end

  initial begin
    logic [7:0]          run_bytes[$];
    logic [7:0]          tail_bytes[$];
    logic [MINLEN_W-1:0] min_lens[6];
    int                  drain;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    rst_n       <= 1'b0;
    steady   = 1'b0;
    hold_req = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every key, shortest and longest runs, literal blocks, literal spanning a write
    run_bytes  = '{8'h00, 8'h1F, 8'hDF, 8'h21, 8'h43, 8'h64, 8'h85, 8'hA6, 8'hC7,
                   8'hE0, 8'hFF, 8'hE2, 8'h00, 8'h80, 8'h7F, 8'hE1};
    tail_bytes = '{8'hA5, 8'h5A, 8'h00, 8'h05};
    foreach (run_bytes[i]) send_byte(run_bytes[i]);
    set_min_len('0);
    foreach (tail_bytes[i]) send_byte(tail_bytes[i]);

    min_lens = '{16'd1, 16'hFFFF, 16'd5, MINLEN_W'($urandom_range(1, 65535)), 16'd40,
                 MINLEN_W'($urandom_range(1, 100))};
    for (int p = 0; p < 6; p++) begin
      set_min_len(min_lens[p]);
      steady = (p == 2 || p == 3);
      if (p == 2) hold_req = 1'b1;
      random_segments(16);
    end
    steady = 1'b0;

    in_tvalid <= 1'b0;
    drain = 0;
    while (pending != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
